// ===== rtl/ismt_pkg.sv =====
`default_nettype none
package ismt_pkg;

	localparam int CODE_W = 21;
	localparam int COUNT_OUT_W = 5;
	localparam int DEFAULT_CAPACITY = 16;
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 8;

	localparam logic FUNC_ADD = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_STEP,
		ST_FINISH,
		ST_EMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic rd_issue;
		logic step;
		logic finish;
		logic emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_end;
		logic out_busy;
	} sts_t;

endpackage
`default_nettype wire

// ===== rtl/ismt_ctrl.sv =====
`default_nettype none
module ismt_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire ismt_pkg::sts_t sts,
	output ismt_pkg::cmd_t     cmd
);
	import ismt_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (sts.scan_end) begin
					state_d = ST_FINISH;
				end else begin
					cmd.rd_issue = 1'b1;
					state_d = ST_STEP;
				end
			end
			ST_STEP: begin
				cmd.step = 1'b1;
				state_d = ST_READ;
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				// wait for the output register to drain
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/ismt_dp.sv =====
`default_nettype none
module ismt_dp #(
	parameter int CAPACITY = ismt_pkg::DEFAULT_CAPACITY
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire ismt_pkg::cmd_t                     cmd,
	output ismt_pkg::sts_t                          sts,
	input  wire logic                               s_func,
	input  wire logic [ismt_pkg::CODE_W-1:0]        s_code_low,
	input  wire logic [ismt_pkg::CODE_W-1:0]        s_code_high,
	input  wire logic                               cfg_we,
	input  wire logic                               cfg_wdata,
	input  wire logic                               m_tready,
	output logic                                    m_tvalid,
	output logic [ismt_pkg::M_TDATA_W-1:0]          m_tdata
);
	import ismt_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int WW = $clog2(CAPACITY + 2);
	localparam int MEM_D = 2 ** (AW + 1);
	localparam int EW = 2 * CODE_W;

	// two banks: scan reads the live bank, an add rebuilds into the other one
	logic [EW-1:0] mem [MEM_D];
	logic [EW-1:0] rd_q;

	logic                func_q;
	logic [CODE_W-1:0]   lo_q;
	logic [CODE_W-1:0]   hi_q;
	logic                ins_q;
	logic                absorbed_q;
	logic                hit_q;
	logic [CW-1:0]       k_q;
	logic [WW-1:0]       wi_q;
	logic [CW-1:0]       n_q;
	logic                bank_q;
	logic                invert_q;
	logic                res_matched_q;
	logic                res_overflow_q;
	logic [COUNT_OUT_W-1:0] res_count_q;
	logic                out_valid_q;
	logic [M_TDATA_W-1:0] out_data_q;

	logic [CODE_W-1:0] ent_s;
	logic [CODE_W-1:0] ent_e;
	logic              before_c;
	logic              absorb_c;
	logic              we_c;
	logic [AW:0]       waddr_c;
	logic [EW-1:0]     wdata_c;
	logic              over_c;
	logic [CW-1:0]     n_next_c;
	logic [31:0]       n_ext_c;
	logic              wi_room_c;

	assign ent_s = rd_q[EW-1:CODE_W];
	assign ent_e = rd_q[CODE_W-1:0];
	// entry ends more than one below the pending low bound
	assign before_c = !ins_q && (({1'b0, ent_e} + 22'd1) < {1'b0, lo_q});
	// entry overlaps or touches the pending interval
	assign absorb_c = !ins_q && !before_c && ({1'b0, ent_s} <= ({1'b0, hi_q} + 22'd1));
	assign wi_room_c = wi_q < WW'(CAPACITY);
	assign over_c = !absorbed_q && (n_q == CW'(CAPACITY));
	assign n_next_c = CW'(wi_q + WW'(1));

	always_comb begin
		we_c = 1'b0;
		waddr_c = {~bank_q, wi_q[AW-1:0]};
		wdata_c = {lo_q, hi_q};
		if (cmd.step && func_q == FUNC_ADD && !absorb_c && wi_room_c) begin
			we_c = 1'b1;
			wdata_c = before_c ? rd_q : {lo_q, hi_q};
		end else if (cmd.finish && func_q == FUNC_ADD && !over_c) begin
			we_c = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we_c) begin
			mem[waddr_c] <= wdata_c;
		end
		if (cmd.rd_issue) begin
			rd_q <= mem[{bank_q, k_q[AW-1:0]}];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= s_func;
			// only an add orders its bounds, a query keeps its code point
			if (s_func == FUNC_ADD && s_code_low > s_code_high) begin
				lo_q <= s_code_high;
				hi_q <= s_code_low;
			end else begin
				lo_q <= s_code_low;
				hi_q <= s_code_high;
			end
		end else if (cmd.step && func_q == FUNC_ADD) begin
			if (absorb_c) begin
				if (ent_s < lo_q) begin
					lo_q <= ent_s;
				end
				if (ent_e > hi_q) begin
					hi_q <= ent_e;
				end
			end else if (!before_c) begin
				// pending goes out, this entry becomes the pending one
				lo_q <= ent_s;
				hi_q <= ent_e;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ins_q <= 1'b0;
			absorbed_q <= 1'b0;
			hit_q <= 1'b0;
			k_q <= '0;
			wi_q <= '0;
			n_q <= '0;
			bank_q <= 1'b0;
			invert_q <= 1'b0;
			res_matched_q <= 1'b0;
			res_overflow_q <= 1'b0;
			res_count_q <= '0;
			out_valid_q <= 1'b0;
			out_data_q <= '0;
		end else begin
			if (cfg_we) begin
				invert_q <= cfg_wdata;
			end
			if (cmd.load) begin
				ins_q <= 1'b0;
				absorbed_q <= 1'b0;
				hit_q <= 1'b0;
				k_q <= '0;
				wi_q <= '0;
			end
			if (cmd.step) begin
				k_q <= k_q + CW'(1);
				if (func_q == FUNC_QUERY) begin
					if (ent_s <= lo_q && lo_q <= ent_e) begin
						hit_q <= 1'b1;
					end
				end else if (absorb_c) begin
					absorbed_q <= 1'b1;
				end else begin
					wi_q <= wi_q + WW'(1);
					if (!before_c) begin
						ins_q <= 1'b1;
					end
				end
			end
			if (cmd.finish) begin
				if (func_q == FUNC_QUERY) begin
					res_matched_q <= hit_q ^ invert_q;
					res_overflow_q <= 1'b0;
					res_count_q <= n_ext_c[COUNT_OUT_W-1:0];
				end else begin
					res_matched_q <= 1'b0;
					res_overflow_q <= over_c;
					if (over_c) begin
						res_count_q <= n_ext_c[COUNT_OUT_W-1:0];
					end else begin
						n_q <= n_next_c;
						bank_q <= ~bank_q;
						res_count_q <= COUNT_OUT_W'(32'(n_next_c));
					end
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				out_data_q <= M_TDATA_W'({res_count_q, res_overflow_q, res_matched_q});
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign n_ext_c = 32'(n_q);
	assign sts.scan_end = (k_q == n_q);
	assign sts.out_busy = out_valid_q && !m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CW'(CAPACITY))
		else $error("interval count above capacity");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> k_q < n_q)
		else $error("scan step past the held entries");

	a_query_keeps_table: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && func_q == FUNC_QUERY |=> $stable(n_q) && $stable(bank_q))
		else $error("query changed the table");

	a_overflow_keeps_table: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && func_q == FUNC_ADD && over_c
		|=> $stable(bank_q) && n_q == CW'(CAPACITY) && res_overflow_q)
		else $error("dropped add changed the table");

	a_merge_no_growth: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && func_q == FUNC_ADD && absorbed_q |=> n_q <= $past(n_q))
		else $error("merging add grew the table");
`endif

endmodule
`default_nettype wire

// ===== rtl/interval_set_match_table_unit.sv =====
`default_nettype none
// channel   dir  signals                    contents (lsb first)
// s_*       in   tvalid tready tdata tuser  tdata: code_low, code_high; tuser: func
// m_*       out  tvalid tready tdata        tdata: matched, overflow, interval_count
// cfg_*     in   we wdata                   wdata: invert
//
// each request is scanned against every held entry in turn: an entry is read from memory,
// then compared or merged; a new request is taken only in the idle state, once the
// previous result has been handed to the output register
// an add rebuilds the table in the second bank, then swaps banks unless it overflows
// reset is asynchronous and empties the table; memory contents are not cleared
// the next request is taken while a result still waits in the output register;
// its own result then waits until that one is taken
module interval_set_match_table_unit #(
	parameter int CAPACITY = ismt_pkg::DEFAULT_CAPACITY
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [ismt_pkg::S_TDATA_W-1:0] s_tdata, // code_low, code_high
	input  wire logic                          s_tuser, // func
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [ismt_pkg::M_TDATA_W-1:0]     m_tdata, // matched, overflow, interval_count
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_wdata
);
	import ismt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	ismt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ismt_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.s_func      (s_tuser),
		.s_code_low  (s_tdata[CODE_W-1:0]),
		.s_code_high (s_tdata[2*CODE_W-1:CODE_W]),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.m_tready    (m_tready),
		.m_tvalid    (m_tvalid),
		.m_tdata     (m_tdata)
	);

endmodule
`default_nettype wire
